[sv/tle_pkg.sv]
`timescale 1ns / 1ps

package tle_pkg;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] key_byte;
      logic       chunk_end;
      logic [3:0] read_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [1:0] line_status;
      logic       run_last;
      logic [3:0] line_length;
      logic [3:0] cursor_pos;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0] index;
      logic       value;
   } csr_item_type;

   localparam logic [1:0] REQ_KEY   = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [1:0] CSR_ECHO_CURSOR = 2'd0;
   localparam logic [1:0] CSR_HIDE_INPUT  = 2'd1;

   localparam logic [1:0] STAT_NONE   = 2'd0;
   localparam logic [1:0] STAT_ENTER  = 2'd1;
   localparam logic [1:0] STAT_CANCEL = 2'd2;

   localparam logic [7:0] K_BS    = 8'h08;
   localparam logic [7:0] K_DEL   = 8'h7f;
   localparam logic [7:0] K_ESC   = 8'h1b;
   localparam logic [7:0] K_CR    = 8'h0d;
   localparam logic [7:0] K_LF    = 8'h0a;
   localparam logic [7:0] K_LBR   = 8'h5b;
   localparam logic [7:0] K_HOME  = 8'h31;
   localparam logic [7:0] K_INS   = 8'h32;
   localparam logic [7:0] K_END   = 8'h34;
   localparam logic [7:0] K_RIGHT = 8'h43;
   localparam logic [7:0] K_LEFT  = 8'h44;
   localparam logic [7:0] K_STAR  = 8'h2a;
   localparam logic [7:0] K_SPACE = 8'h20;
   localparam logic [7:0] K_TILDE = 8'h7e;
   localparam logic [7:0] K_NUL   = 8'h00;

endpackage

[sv/tle_chan.sv]
`timescale 1ns / 1ps

interface tle_chan #(parameter type data_type = logic);
   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[sv/terminal_line_editor.sv]
`timescale 1ns / 1ps

// sequence: an item steps through the states PRE, LRD/LEM, TAIL, SUF, REP and FIN;
// edits read and echo each shifted character from the line store plus the fixed echo bytes
// throughput: one item at a time, taken only in the idle state and set by the echo
// byte sequencer; a result stalled at the output stalls the sequence
// reset: synchronous, clears length, cursor and escape phase, echo_cursor 1,
// hide_input 0; the line store is not cleared

module terminal_line_editor #(
   parameter int LINE_CAPACITY = 16
) (
   input logic   clock,
   input logic   reset,
   tle_chan.sink   req_chan,
   tle_chan.source rsp_chan,
   tle_chan.sink   csr_chan
);

   localparam int LW = $clog2(LINE_CAPACITY);
   localparam int CW = (LW > 4) ? LW : 4;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PRE  = 3'd1;
   localparam logic [2:0] ST_LRD  = 3'd2;
   localparam logic [2:0] ST_LEM  = 3'd3;
   localparam logic [2:0] ST_TAIL = 3'd4;
   localparam logic [2:0] ST_SUF  = 3'd5;
   localparam logic [2:0] ST_REP  = 3'd6;
   localparam logic [2:0] ST_FIN  = 3'd7;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ESC  = 2'd1;
   localparam logic [1:0] PH_CSI  = 2'd2;
   localparam logic [1:0] PH_SKIP = 2'd3;

   localparam logic [1:0] WM_NONE  = 2'd0;
   localparam logic [1:0] WM_DOWN  = 2'd1;
   localparam logic [1:0] WM_CARRY = 2'd2;

   tle_pkg::req_item_type req;
   tle_pkg::rsp_item_type rsp_ff, rsp_in;
   logic rsp_v_ff, rsp_v_in;

   logic [2:0]    state_ff, state_in;
   logic [LW-1:0] len_ff, len_in, cur_ff, cur_in;
   logic [1:0]    esc_ff, esc_in;
   logic          echo_ff, echo_in, hide_ff, hide_in;
   logic [1:0]    st_ff, st_in;
   logic [7:0]    pre_ff [3];
   logic [7:0]    pre_in [3];
   logic [1:0]    npre_ff, npre_in;
   logic [LW-1:0] i_ff, i_in, hi_ff, hi_in;
   logic [1:0]    wm_ff, wm_in;
   logic          mask_ff, mask_in, tail_ff, tail_in;
   logic [7:0]    carry_ff, carry_in;
   logic [7:0]    suf_ff [2];
   logic [7:0]    suf_in [2];
   logic [1:0]    nsuf_ff, nsuf_in;
   logic [LW-1:0] rep_ff, rep_in;
   logic          gesc_ff, gesc_in;
   logic [7:0]    gch_ff, gch_in;
   logic [1:0]    k_ff, k_in;
   logic [7:0]    pend_ff, pend_in;
   logic          pend_v_ff, pend_v_in;

   logic          req_go, out_free, emit_req, emit_ok, emit_fire, fin_fire;
   logic [7:0]    emit_byte;
   logic          ram_we, ram_re;
   logic [LW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;
   logic [LW-1:0] diff;
   logic [CW-1:0] ridx_cw, len_cw, cur_cw;

   assign req = req_chan.data;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_go = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_v_ff;
   assign rsp_chan.data = rsp_ff;

   assign diff = len_ff - cur_ff;
   assign ridx_cw = CW'(req.read_index);
   assign len_cw = CW'(len_ff);
   assign cur_cw = CW'(cur_ff);

   tle_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      cur_in = cur_ff;
      esc_in = esc_ff;
      echo_in = echo_ff;
      hide_in = hide_ff;
      st_in = st_ff;
      pre_in = pre_ff;
      npre_in = npre_ff;
      i_in = i_ff;
      hi_in = hi_ff;
      wm_in = wm_ff;
      mask_in = mask_ff;
      tail_in = tail_ff;
      carry_in = carry_ff;
      suf_in = suf_ff;
      nsuf_in = nsuf_ff;
      rep_in = rep_ff;
      gesc_in = gesc_ff;
      gch_in = gch_ff;
      k_in = k_ff;
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      rsp_in = rsp_ff;
      rsp_v_in = rsp_v_ff;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = i_ff;
      ram_raddr = i_ff;
      ram_wdata = ram_rdata;
      emit_req = 1'b0;
      emit_byte = tle_pkg::K_NUL;
      fin_fire = 1'b0;

      if (csr_chan.valid) begin
         if (csr_chan.data.index == tle_pkg::CSR_ECHO_CURSOR) begin
            echo_in = csr_chan.data.value;
         end else if (csr_chan.data.index == tle_pkg::CSR_HIDE_INPUT) begin
            hide_in = csr_chan.data.value;
         end
      end

      // decode: final length, cursor and phase now, echo program for the sequencer
      if (req_go) begin
         state_in = ST_PRE;
         st_in = tle_pkg::STAT_NONE;
         npre_in = 2'd0;
         i_in = '0;
         hi_in = '0;
         wm_in = WM_NONE;
         mask_in = 1'b0;
         tail_in = 1'b0;
         carry_in = req.key_byte;
         nsuf_in = 2'd0;
         rep_in = '0;
         gesc_in = 1'b0;
         gch_in = tle_pkg::K_RIGHT;
         k_in = 2'd0;
         unique case (req.req_type)
            tle_pkg::REQ_KEY: begin
               esc_in = PH_IDLE;
               if (esc_ff == PH_SKIP) begin
                  esc_in = PH_SKIP;
               end else if (esc_ff == PH_ESC) begin
                  if (req.key_byte == tle_pkg::K_LBR) begin
                     esc_in = PH_CSI;
                  end
               end else if (esc_ff == PH_CSI) begin
                  if (req.key_byte == tle_pkg::K_RIGHT) begin
                     if (cur_ff < len_ff) begin
                        cur_in = cur_ff + 1'b1;
                        if (echo_ff) begin
                           npre_in = 2'd3;
                           pre_in[0] = tle_pkg::K_ESC;
                           pre_in[1] = tle_pkg::K_LBR;
                           pre_in[2] = tle_pkg::K_RIGHT;
                        end
                     end
                  end else if (req.key_byte == tle_pkg::K_LEFT) begin
                     if (cur_ff != '0) begin
                        cur_in = cur_ff - 1'b1;
                        if (echo_ff) begin
                           npre_in = 2'd1;
                           pre_in[0] = tle_pkg::K_BS;
                        end
                     end
                  end else if (req.key_byte == tle_pkg::K_HOME) begin
                     cur_in = '0;
                     rep_in = echo_ff ? cur_ff : '0;
                     gesc_in = 1'b1;
                     gch_in = tle_pkg::K_LEFT;
                     esc_in = PH_SKIP;
                  end else if (req.key_byte == tle_pkg::K_END) begin
                     cur_in = len_ff;
                     rep_in = echo_ff ? diff : '0;
                     gesc_in = 1'b1;
                     gch_in = tle_pkg::K_RIGHT;
                     esc_in = PH_SKIP;
                  end else if (req.key_byte == tle_pkg::K_INS) begin
                     esc_in = PH_SKIP;
                  end
               end else if (req.key_byte == tle_pkg::K_ESC) begin
                  if (req.chunk_end) begin
                     if (len_ff != '0) begin
                        st_in = tle_pkg::STAT_CANCEL;
                     end
                  end else begin
                     esc_in = PH_ESC;
                  end
               end else if (req.key_byte == tle_pkg::K_BS) begin
                  if (cur_ff != '0 && len_ff != '0) begin
                     npre_in = 2'd1;
                     pre_in[0] = tle_pkg::K_BS;
                     i_in = cur_ff;
                     hi_in = len_ff;
                     wm_in = WM_DOWN;
                     nsuf_in = 2'd2;
                     suf_in[0] = tle_pkg::K_SPACE;
                     suf_in[1] = tle_pkg::K_BS;
                     rep_in = diff;
                     cur_in = cur_ff - 1'b1;
                     len_in = len_ff - 1'b1;
                  end
               end else if (req.key_byte == tle_pkg::K_DEL) begin
                  if (cur_ff < len_ff) begin
                     i_in = cur_ff + 1'b1;
                     hi_in = len_ff;
                     wm_in = WM_DOWN;
                     nsuf_in = 2'd1;
                     suf_in[0] = tle_pkg::K_SPACE;
                     rep_in = diff;
                     len_in = len_ff - 1'b1;
                  end
               end else if (req.key_byte == tle_pkg::K_CR) begin
                  npre_in = 2'd2;
                  pre_in[0] = tle_pkg::K_CR;
                  pre_in[1] = tle_pkg::K_LF;
                  st_in = tle_pkg::STAT_ENTER;
                  esc_in = PH_SKIP;
               end else if (req.key_byte >= tle_pkg::K_SPACE && req.key_byte <= tle_pkg::K_TILDE
                            && len_ff < LW'(LINE_CAPACITY - 1)) begin
                  npre_in = 2'd1;
                  pre_in[0] = hide_ff ? tle_pkg::K_STAR : req.key_byte;
                  i_in = cur_ff;
                  hi_in = len_ff;
                  wm_in = WM_CARRY;
                  mask_in = hide_ff;
                  tail_in = 1'b1;
                  rep_in = diff;
                  cur_in = cur_ff + 1'b1;
                  len_in = len_ff + 1'b1;
               end
               if (req.chunk_end) begin
                  esc_in = PH_IDLE;
               end
            end
            tle_pkg::REQ_READ: begin
               if (ridx_cw < len_cw) begin
                  i_in = ridx_cw[LW-1:0];
                  hi_in = ridx_cw[LW-1:0] + 1'b1;
               end else begin
                  npre_in = 2'd1;
                  pre_in[0] = tle_pkg::K_NUL;
               end
            end
            tle_pkg::REQ_CLEAR: begin
               len_in = '0;
               cur_in = '0;
               esc_in = PH_IDLE;
            end
            default: begin
            end
         endcase
      end

      out_free = !rsp_v_ff || rsp_chan.ready;
      emit_ok = !pend_v_ff || out_free;

      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_PRE: begin
            if (k_ff < npre_ff) begin
               emit_req = 1'b1;
               emit_byte = pre_ff[k_ff];
               if (emit_ok) begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               k_in = 2'd0;
               state_in = ST_LRD;
            end
         end
         ST_LRD: begin
            if (i_ff < hi_ff) begin
               ram_re = 1'b1;
               state_in = ST_LEM;
            end else begin
               state_in = ST_TAIL;
            end
         end
         ST_LEM: begin
            emit_req = 1'b1;
            emit_byte = mask_ff ? tle_pkg::K_STAR : ram_rdata;
            if (emit_ok) begin
               if (wm_ff == WM_DOWN) begin
                  ram_we = 1'b1;
                  ram_waddr = i_ff - 1'b1;
                  ram_wdata = ram_rdata;
               end else if (wm_ff == WM_CARRY) begin
                  ram_we = 1'b1;
                  ram_waddr = i_ff;
                  ram_wdata = carry_ff;
                  carry_in = ram_rdata;
               end
               i_in = i_ff + 1'b1;
               state_in = ST_LRD;
            end
         end
         ST_TAIL: begin
            if (tail_ff) begin
               ram_we = 1'b1;
               ram_waddr = hi_ff;
               ram_wdata = carry_ff;
            end
            state_in = ST_SUF;
         end
         ST_SUF: begin
            if (k_ff < nsuf_ff) begin
               emit_req = 1'b1;
               emit_byte = suf_ff[k_ff[0]];
               if (emit_ok) begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               k_in = 2'd0;
               state_in = ST_REP;
            end
         end
         ST_REP: begin
            if (rep_ff != '0) begin
               emit_req = 1'b1;
               if (!gesc_ff) begin
                  emit_byte = tle_pkg::K_BS;
               end else if (k_ff == 2'd0) begin
                  emit_byte = tle_pkg::K_ESC;
               end else if (k_ff == 2'd1) begin
                  emit_byte = tle_pkg::K_LBR;
               end else begin
                  emit_byte = gch_ff;
               end
               if (emit_ok) begin
                  if (!gesc_ff || k_ff == 2'd2) begin
                     k_in = 2'd0;
                     rep_in = rep_ff - 1'b1;
                  end else begin
                     k_in = k_ff + 1'b1;
                  end
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               fin_fire = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      emit_fire = emit_req && emit_ok;

      if (rsp_chan.ready) begin
         rsp_v_in = 1'b0;
      end
      if ((emit_fire && pend_v_ff) || fin_fire) begin
         rsp_v_in = 1'b1;
         rsp_in.out_byte = (fin_fire && !pend_v_ff) ? tle_pkg::K_NUL : pend_ff;
         rsp_in.byte_valid = pend_v_ff;
         rsp_in.line_status = st_ff;
         rsp_in.run_last = fin_fire;
         rsp_in.line_length = len_cw[3:0];
         rsp_in.cursor_pos = cur_cw[3:0];
      end
      if (emit_fire) begin
         pend_in = emit_byte;
         pend_v_in = 1'b1;
      end else if (fin_fire) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         cur_ff <= '0;
         esc_ff <= PH_IDLE;
         echo_ff <= 1'b1;
         hide_ff <= 1'b0;
         pend_v_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         k_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         cur_ff <= cur_in;
         esc_ff <= esc_in;
         echo_ff <= echo_in;
         hide_ff <= hide_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff <= rsp_v_in;
         k_ff <= k_in;
      end
      st_ff <= st_in;
      pre_ff <= pre_in;
      npre_ff <= npre_in;
      i_ff <= i_in;
      hi_ff <= hi_in;
      wm_ff <= wm_in;
      mask_ff <= mask_in;
      tail_ff <= tail_in;
      carry_ff <= carry_in;
      suf_ff <= suf_in;
      nsuf_ff <= nsuf_in;
      rep_ff <= rep_in;
      gesc_ff <= gesc_in;
      gch_ff <= gch_in;
      pend_ff <= pend_in;
      rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_cursor_in_line: assert property (@(posedge clock) disable iff (reset)
      cur_ff <= len_ff)
      else $error("cursor beyond line length");

   a_len_in_capacity: assert property (@(posedge clock) disable iff (reset)
      len_ff < LW'(LINE_CAPACITY - 1) || len_ff == LW'(LINE_CAPACITY - 1))
      else $error("line length beyond capacity");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_v_ff)
      else $error("pending echo byte left at idle");

   a_fin_gives_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (rsp_v_ff && rsp_ff.run_last))
      else $error("run end not delivered as last item");
`endif

endmodule

[sv/tle_ram.sv]
`timescale 1ns / 1ps

module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import tle_pkg::*;

   localparam int CAP = 16;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      req_item_type r;
      bit           typed;
      rsp_item_type e;
   } stim_row_type;

   logic clock;
   logic reset;

   tle_chan #(.data_type(req_item_type)) req_chan ();
   tle_chan #(.data_type(rsp_item_type)) rsp_chan ();
   tle_chan #(.data_type(csr_item_type)) csr_chan ();

   terminal_line_editor u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // editor state as predicted
   logic [7:0] line_mem [CAP];
   int unsigned line_len_q;
   int unsigned cursor_q;
   int unsigned esc_phase;
   bit echo_moves;
   bit mask_echo;

   rsp_item_type echo_expect_q[$];
   int errors = 0;
   int items_sent;
   int results_seen = 0;
   int cycle_count = 0;
   int send_idle;
   int recv_stall;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic req_item_type mk(logic [1:0] rt, logic [7:0] kb, logic ce,
                                       logic [3:0] ri);
      req_item_type it;
      it.req_type = rt;
      it.key_byte = kb;
      it.chunk_end = ce;
      it.read_index = ri;
      return it;
   endfunction

   function automatic void predict_item(req_item_type it);
      logic [7:0] echo[$];
      logic [1:0] st;
      bit rd;
      logic [7:0] rb;
      int unsigned ph;
      int unsigned diff;
      int unsigned n;
      logic [7:0] key;
      rsp_item_type o;
      st = STAT_NONE;
      rd = 0;
      rb = K_NUL;
      key = it.key_byte;
      case (it.req_type)
         REQ_KEY: begin
            ph = esc_phase;
            esc_phase = 0;
            if (ph == 3) begin
               esc_phase = 3;
            end else if (ph == 1) begin
               if (key == K_LBR) esc_phase = 2;
            end else if (ph == 2) begin
               if (key == K_RIGHT) begin
                  if (cursor_q < line_len_q) begin
                     cursor_q++;
                     if (echo_moves) echo = {echo, K_ESC, K_LBR, K_RIGHT};
                  end
               end else if (key == K_LEFT) begin
                  if (cursor_q > 0) begin
                     cursor_q--;
                     if (echo_moves) echo.push_back(K_BS);
                  end
               end else if (key == K_HOME) begin
                  while (cursor_q != 0) begin
                     cursor_q--;
                     if (echo_moves) echo = {echo, K_ESC, K_LBR, K_LEFT};
                  end
                  esc_phase = 3;
               end else if (key == K_END) begin
                  while (cursor_q < line_len_q) begin
                     cursor_q++;
                     if (echo_moves) echo = {echo, K_ESC, K_LBR, K_RIGHT};
                  end
                  esc_phase = 3;
               end else if (key == K_INS) begin
                  esc_phase = 3;
               end
            end else if (key == K_ESC) begin
               if (it.chunk_end) begin
                  if (line_len_q != 0) st = STAT_CANCEL;
               end else begin
                  esc_phase = 1;
               end
            end else if (key == K_BS) begin
               if (cursor_q > 0 && line_len_q > 0) begin
                  diff = line_len_q - cursor_q;
                  echo.push_back(K_BS);
                  for (int i = cursor_q; i < line_len_q; i++) echo.push_back(line_mem[i]);
                  for (int i = cursor_q; i < line_len_q; i++) line_mem[i-1] = line_mem[i];
                  cursor_q--;
                  line_len_q--;
                  echo = {echo, K_SPACE, K_BS};
                  repeat (diff) echo.push_back(K_BS);
               end
            end else if (key == K_DEL) begin
               if (cursor_q < line_len_q) begin
                  diff = line_len_q - cursor_q;
                  for (int i = cursor_q; i + 1 < line_len_q; i++) line_mem[i] = line_mem[i+1];
                  line_len_q--;
                  for (int i = cursor_q; i < line_len_q; i++) echo.push_back(line_mem[i]);
                  echo.push_back(K_SPACE);
                  repeat (diff) echo.push_back(K_BS);
               end
            end else if (key == K_CR) begin
               echo = {echo, K_CR, K_LF};
               st = STAT_ENTER;
               esc_phase = 3;
            end else if (key >= K_SPACE && key <= K_TILDE && line_len_q < CAP - 1) begin
               diff = line_len_q - cursor_q;
               echo.push_back(mask_echo ? K_STAR : key);
               for (int i = cursor_q; i < line_len_q; i++)
                  echo.push_back(mask_echo ? K_STAR : line_mem[i]);
               for (int i = line_len_q; i > cursor_q; i--) line_mem[i] = line_mem[i-1];
               line_mem[cursor_q] = key;
               repeat (diff) echo.push_back(K_BS);
               cursor_q++;
               line_len_q++;
            end
            if (it.chunk_end) esc_phase = 0;
         end
         REQ_READ: begin
            rd = 1;
            if (it.read_index < line_len_q) rb = line_mem[it.read_index];
         end
         REQ_CLEAR: begin
            line_len_q = 0;
            cursor_q = 0;
            esc_phase = 0;
         end
         default: ;
      endcase
      n = (rd || echo.size() == 0) ? 1 : echo.size();
      for (int k = 0; k < n; k++) begin
         o.out_byte = rd ? rb : (echo.size() != 0 ? echo[k] : K_NUL);
         o.byte_valid = rd || echo.size() != 0;
         o.line_status = st;
         o.run_last = (k + 1 == n);
         o.line_length = line_len_q[3:0];
         o.cursor_pos = cursor_q[3:0];
         echo_expect_q.push_back(o);
      end
   endfunction

   task automatic send_item(req_item_type it, bit typed = 0,
                            rsp_item_type e = '0);
      int gap;
      if ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data <= it;
      do @(posedge clock); while (!req_chan.ready);
      predict_item(it);
      if (typed) begin
         void'(echo_expect_q.pop_back());
         echo_expect_q.push_back(e);
      end
      items_sent++;
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (echo_expect_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic val);
      csr_chan.valid <= 1'b1;
      csr_chan.data <= '{index: idx, value: val};
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      if (idx == CSR_ECHO_CURSOR) echo_moves = val;
      else mask_echo = val;
   endtask

   task automatic random_burst(int count);
      int sent;
      int sel;
      logic [7:0] third;
      bit ce;
      sent = 0;
      while (sent < count) begin
         sel = $urandom_range(99);
         if (sel < 38) begin
            send_item(mk(REQ_KEY, 8'($urandom_range(8'h20, 8'h7e)),
                         $urandom_range(99) < 20, 4'($urandom)));
            sent++;
         end else if (sel < 52) begin
            case ($urandom_range(5))
               0: third = K_RIGHT;
               1: third = K_LEFT;
               2: third = K_HOME;
               3: third = K_END;
               4: third = K_INS;
               default: third = 8'($urandom);
            endcase
            ce = 1'($urandom_range(1));
            send_item(mk(REQ_KEY, K_ESC, 1'b0, 4'($urandom)));
            send_item(mk(REQ_KEY, $urandom_range(9) == 0 ? 8'($urandom) : K_LBR,
                         1'b0, 4'($urandom)));
            send_item(mk(REQ_KEY, third, ce, 4'($urandom)));
            if (!ce) send_item(mk(REQ_KEY, 8'($urandom_range(8'h20, 8'h7e)), 1'b1, 4'd0));
            sent += ce ? 3 : 4;
         end else if (sel < 60) begin
            send_item(mk(REQ_KEY, K_BS, 1'($urandom_range(1)), 4'($urandom)));
            sent++;
         end else if (sel < 66) begin
            send_item(mk(REQ_KEY, K_DEL, 1'($urandom_range(1)), 4'($urandom)));
            sent++;
         end else if (sel < 70) begin
            send_item(mk(REQ_KEY, K_CR, 1'($urandom_range(1)), 4'($urandom)));
            sent++;
         end else if (sel < 78) begin
            send_item(mk(REQ_READ, 8'($urandom), 1'($urandom_range(1)), 4'($urandom)));
            sent++;
         end else if (sel < 83) begin
            send_item(mk(REQ_CLEAR, 8'($urandom), 1'($urandom_range(1)), 4'($urandom)));
            sent++;
         end else if (sel < 87) begin
            send_item(mk(REQ_KEY, K_ESC, 1'b1, 4'($urandom)));
            sent++;
         end else begin
            send_item(mk(2'($urandom), 8'($urandom), 1'($urandom_range(1)), 4'($urandom)));
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.data;
         results_seen++;
         if (echo_expect_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
         end else begin
            want = echo_expect_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time,
                        want.out_byte, got.out_byte);
               errors++;
            end
            if (got.byte_valid !== want.byte_valid) begin
               $display("%0t: byte_valid expected %b actual %b", $time,
                        want.byte_valid, got.byte_valid);
               errors++;
            end
            if (got.line_status !== want.line_status) begin
               $display("%0t: line_status expected %0d actual %0d", $time,
                        want.line_status, got.line_status);
               errors++;
            end
            if (got.run_last !== want.run_last) begin
               $display("%0t: run_last expected %b actual %b", $time,
                        want.run_last, got.run_last);
               errors++;
            end
            if (got.line_length !== want.line_length) begin
               $display("%0t: line_length expected %0d actual %0d", $time,
                        want.line_length, got.line_length);
               errors++;
            end
            if (got.cursor_pos !== want.cursor_pos) begin
               $display("%0t: cursor_pos expected %0d actual %0d", $time,
                        want.cursor_pos, got.cursor_pos);
               errors++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall);
   end

   stim_row_type directed [] = '{
      '{mk(REQ_READ, K_NUL, 1'b0, 4'd0), 1, '{K_NUL, 1'b1, STAT_NONE, 1'b1, 4'd0, 4'd0}},
      '{mk(REQ_KEY, K_ESC, 1'b1, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd0, 4'd0}},
      '{mk(2'd3, 8'hff, 1'b1, 4'hf), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd0, 4'd0}},
      '{mk(REQ_KEY, K_SPACE, 1'b0, 4'd0), 1, '{K_SPACE, 1'b1, STAT_NONE, 1'b1, 4'd1, 4'd1}},
      '{mk(REQ_KEY, K_TILDE, 1'b0, 4'd0), 1, '{K_TILDE, 1'b1, STAT_NONE, 1'b1, 4'd2, 4'd2}},
      '{mk(REQ_KEY, 8'h1f, 1'b0, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd2, 4'd2}},
      '{mk(REQ_KEY, 8'hff, 1'b0, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd2, 4'd2}},
      '{mk(REQ_KEY, K_ESC, 1'b0, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd2, 4'd2}},
      '{mk(REQ_KEY, K_LBR, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_LEFT, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_ESC, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_LBR, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_HOME, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, 8'h61, 1'b1, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd2, 4'd0}},
      '{mk(REQ_KEY, K_BS, 1'b0, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd2, 4'd0}},
      '{mk(REQ_KEY, K_DEL, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_ESC, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, 8'h41, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_ESC, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_LBR, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_END, 1'b1, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_BS, 1'b0, 4'd0), 0, '0},
      '{mk(REQ_KEY, K_CR, 1'b1, 4'd0), 0, '0},
      '{mk(REQ_READ, K_NUL, 1'b0, 4'hf), 1, '{K_NUL, 1'b1, STAT_NONE, 1'b1, 4'd0, 4'd0}},
      '{mk(REQ_KEY, K_ESC, 1'b1, 4'd0), 1, '{K_NUL, 1'b0, STAT_NONE, 1'b1, 4'd0, 4'd0}}
   };

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data = '0;
      line_len_q = 0;
      cursor_q = 0;
      esc_phase = 0;
      echo_moves = 1;
      mask_echo = 0;
      items_sent = 0;
      send_idle = 0;
      recv_stall = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_item(directed[i].r, directed[i].typed, directed[i].e);
      // fill past capacity, then walk and edit a full line
      repeat (17) send_item(mk(REQ_KEY, 8'($urandom_range(8'h20, 8'h7e)), 1'b0, 4'd0));
      for (int i = 0; i < 16; i++) send_item(mk(REQ_READ, K_NUL, 1'b0, 4'(i)));
      send_item(mk(REQ_KEY, K_ESC, 1'b0, 4'd0));
      send_item(mk(REQ_KEY, K_LBR, 1'b0, 4'd0));
      send_item(mk(REQ_KEY, K_HOME, 1'b1, 4'd0));
      send_item(mk(REQ_KEY, K_DEL, 1'b1, 4'd0));
      send_item(mk(REQ_KEY, 8'h7e, 1'b1, 4'd0));
      drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 55; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 55; end
            default: begin send_idle = 31; recv_stall = 31; end
         endcase
         write_csr(CSR_ECHO_CURSOR, p[0]);
         write_csr(CSR_HIDE_INPUT, p[1]);
         random_burst(12);
         drain();
         random_burst(12);
         drain();
      end

      $display("%0d items sent, %0d results checked over four echo/mask settings",
               items_sent, results_seen);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
